[hdl/wlft_pkg.sv]
package wlft_pkg;

  localparam logic [1:0] CMD_INDEX = 2'd1;
  localparam int unsigned CLR_BIT = 1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_MSTART,
    OP_MSTEP,
    OP_MWB,
    OP_DSTART,
    OP_DSTEP,
    OP_DWB,
    OP_OUT
  } op_t;

  typedef enum logic [3:0] {
    PH_XW,
    PH_YW,
    PH_XX,
    PH_XY,
    PH_DEN0,
    PH_DEN1,
    PH_NUM0,
    PH_NUM1,
    PH_SLOPE,
    PH_ICPT_M,
    PH_ICPT,
    PH_MID,
    PH_PRED,
    PH_SQ,
    PH_ESUM
  } phase_t;

  typedef struct packed {
    op_t    op;
    phase_t phase;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic den_zero;
    logic sw_zero;
    logic out_busy;
  } sts_t;

endpackage

[hdl/wlft_ctrl.sv]
module wlft_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_cmd,
  input  wlft_pkg::sts_t  sts,
  output wlft_pkg::cmd_t  cmd
);
  import wlft_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MSTART,
    ST_MSTEP,
    ST_MWB,
    ST_DSTART,
    ST_DSTEP,
    ST_DWB,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  always_comb begin
    cmd.op    = OP_NONE;
    cmd.phase = phase_r;
    state_nxt = state_r;
    phase_nxt = phase_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd[CLR_BIT]) begin
            cmd.op = OP_CLEAR;
          end else begin
            cmd.op    = OP_LOAD;
            phase_nxt = PH_XW;
            state_nxt = ST_MSTART;
          end
        end
      end
      ST_MSTART: begin
        cmd.op = OP_MSTART;
        if (phase_r == PH_ICPT_M && sts.sw_zero) begin
          phase_nxt = PH_MID;
        end else begin
          state_nxt = ST_MSTEP;
        end
      end
      ST_MSTEP: begin
        cmd.op = OP_MSTEP;
        if (sts.mul_done) state_nxt = ST_MWB;
      end
      ST_MWB: begin
        cmd.op = OP_MWB;
        if (phase_r == PH_ESUM) begin
          phase_nxt = PH_XW;
          state_nxt = ST_FIN;
        end else begin
          phase_nxt = phase_t'(phase_r + 4'd1);
          if (phase_r == PH_NUM1 || phase_r == PH_ICPT_M) state_nxt = ST_DSTART;
          else state_nxt = ST_MSTART;
        end
      end
      ST_DSTART: begin
        cmd.op = OP_DSTART;
        if (phase_r == PH_SLOPE && sts.den_zero) begin
          phase_nxt = PH_ICPT_M;
          state_nxt = ST_MSTART;
        end else begin
          state_nxt = ST_DSTEP;
        end
      end
      ST_DSTEP: begin
        cmd.op = OP_DSTEP;
        if (sts.div_done) state_nxt = ST_DWB;
      end
      ST_DWB: begin
        cmd.op    = OP_DWB;
        phase_nxt = phase_t'(phase_r + 4'd1);
        state_nxt = ST_MSTART;
      end
      ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.op    = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_XW;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_cmd[CLR_BIT] |=> state_r == ST_MSTART && phase_r == PH_XW)
    else $error("point word did not start the sequence");

  a_div_phase: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DSTART |-> (phase_r == PH_SLOPE || phase_r == PH_ICPT))
    else $error("divide started in a multiply phase");

endmodule

[hdl/wlft_dpath.sv]
module wlft_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  wlft_pkg::cmd_t      cmd,
  output wlft_pkg::sts_t      sts,
  input  logic [1:0]          in_cmd,
  input  logic signed [15:0]  in_x_value,
  input  logic signed [15:0]  in_y_value,
  input  logic [7:0]          in_weight,
  input  logic                out_ready,
  output logic                out_valid,
  output logic signed [31:0]  out_slope,
  output logic signed [31:0]  out_intercept,
  output logic signed [31:0]  out_mid_value,
  output logic [30:0]         out_max_error,
  output logic [62:0]         out_error_sum,
  output logic signed [15:0]  out_y_low,
  output logic signed [15:0]  out_y_high,
  output logic signed [15:0]  out_x_low,
  output logic signed [15:0]  out_x_high,
  output logic [31:0]         out_point_count,
  output logic                out_flat_fit,
  output logic                out_no_weight
);
  import wlft_pkg::*;

  localparam logic [39:0]        SW_MAX  = {40{1'b1}};
  localparam logic signed [55:0] S56_MAX = {1'b0, {55{1'b1}}};
  localparam logic signed [55:0] S56_MIN = {1'b1, {55{1'b0}}};
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
  localparam logic [62:0]        ERR_MAX = {63{1'b1}};
  localparam logic [30:0]        E31_MAX = {31{1'b1}};
  localparam logic [5:0]         DIV_STEPS = 6'd33;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) sat32 = 32'sh7FFF_FFFF;
    else if (v < 64'shFFFF_FFFF_8000_0000) sat32 = 32'sh8000_0000;
    else sat32 = v[31:0];
  endfunction

  logic [31:0]        count_r;
  logic [39:0]        sw_r;
  logic signed [55:0] sx_r, sy_r;
  logic [63:0]        sx2_r;
  logic signed [63:0] sxy_r;
  logic [62:0]        esum_r;
  logic [30:0]        worst_r;
  logic signed [15:0] xlo_r, xhi_r, ylo_r, yhi_r;
  logic [5:0]         dcnt_r;
  logic               out_valid_r;

  logic signed [15:0]  x_r, y_r;
  logic [7:0]          w_r;
  logic signed [25:0]  xw_r, yw_r;
  logic signed [159:0] t0_r, t1_r;
  logic signed [31:0]  slope_r, icpt_r, mid_r;
  logic signed [63:0]  e_r;
  logic [61:0]         sq_r;
  logic                flat_r, nowt_r;
  logic [63:0]         ma_r, mb_r;
  logic [1:0]          dig_r;
  logic [127:0]        p_r;
  logic                mneg_r;
  logic [159:0]        rem_r, dsh_r;
  logic [32:0]         q_r;
  logic                dneg_r;

  logic signed [31:0] o_slope_r, o_icpt_r, o_mid_r;
  logic [30:0]        o_worst_r;
  logic [62:0]        o_esum_r;
  logic signed [15:0] o_ylo_r, o_yhi_r, o_xlo_r, o_xhi_r;
  logic [31:0]        o_count_r;
  logic               o_flat_r, o_nowt_r;

  logic [32:0]        cnt1;
  logic signed [15:0] x_eff;
  logic [40:0]        sw_sum;
  logic [15:0]        x_mag, y_mag;
  logic [25:0]        xw_mag, yw_mag;
  logic [55:0]        sx_mag, sy_mag;
  logic [63:0]        sxy_mag;
  logic [31:0]        slope_mag;
  logic signed [16:0] xsum;
  logic [16:0]        xsum_mag;
  logic [63:0]        e_mag;
  logic [30:0]        err_sat;
  logic [63:0]        op_a, op_b;
  logic               op_n;
  logic [79:0]        pp;
  logic [127:0]       p_add;
  logic signed [159:0] sp;
  logic signed [56:0] s57x, s57y;
  logic [64:0]        s65u;
  logic signed [64:0] s65s;
  logic signed [63:0] mid_v, pred_v, ysh;
  logic [47:0]        pq9;
  logic [47:0]        pq8;
  logic [62:0]        err_add;
  logic [63:0]        esum_s;
  logic signed [159:0] dnum, dden;
  logic [159:0]       dnum_mag, dden_mag;
  logic               dge;
  logic [31:0]        qm;
  logic signed [31:0] dres;

  always_comb begin
    cnt1 = {1'b0, count_r} + 33'd1;
    if (in_cmd == CMD_INDEX) begin
      x_eff = (cnt1 >= 33'd128) ? 16'sh7FFF : {1'b0, cnt1[6:0], 8'h00};
    end else begin
      x_eff = in_x_value;
    end
    sw_sum = {1'b0, sw_r} + {33'b0, in_weight};

    x_mag     = x_r[15] ? (~x_r + 1'b1) : x_r;
    y_mag     = y_r[15] ? (~y_r + 1'b1) : y_r;
    xw_mag    = xw_r[25] ? (~xw_r + 1'b1) : xw_r;
    yw_mag    = yw_r[25] ? (~yw_r + 1'b1) : yw_r;
    sx_mag    = sx_r[55] ? (~sx_r + 1'b1) : sx_r;
    sy_mag    = sy_r[55] ? (~sy_r + 1'b1) : sy_r;
    sxy_mag   = sxy_r[63] ? (~sxy_r + 1'b1) : sxy_r;
    slope_mag = slope_r[31] ? (~slope_r + 1'b1) : slope_r;
    xsum      = {xhi_r[15], xhi_r} + {xlo_r[15], xlo_r};
    xsum_mag  = xsum[16] ? (~xsum + 1'b1) : xsum;
    e_mag     = e_r[63] ? (~e_r + 1'b1) : e_r;
    err_sat   = (e_mag > {33'b0, E31_MAX}) ? E31_MAX : e_mag[30:0];

    op_a = '0;
    op_b = '0;
    op_n = 1'b0;
    case (cmd.phase)
      PH_XW: begin
        op_a = {48'b0, x_mag};
        op_b = {56'b0, w_r};
        op_n = x_r[15];
      end
      PH_YW: begin
        op_a = {48'b0, y_mag};
        op_b = {56'b0, w_r};
        op_n = y_r[15];
      end
      PH_XX: begin
        op_a = {38'b0, xw_mag};
        op_b = {38'b0, xw_mag};
      end
      PH_XY: begin
        op_a = {38'b0, xw_mag};
        op_b = {38'b0, yw_mag};
        op_n = xw_r[25] ^ yw_r[25];
      end
      PH_DEN0: begin
        op_a = {24'b0, sw_r};
        op_b = sx2_r;
      end
      PH_DEN1: begin
        op_a = {8'b0, sx_mag};
        op_b = {8'b0, sx_mag};
      end
      PH_NUM0: begin
        op_a = {24'b0, sw_r};
        op_b = sxy_mag;
        op_n = sxy_r[63];
      end
      PH_NUM1: begin
        op_a = {8'b0, sx_mag};
        op_b = {8'b0, sy_mag};
        op_n = sx_r[55] ^ sy_r[55];
      end
      PH_ICPT_M: begin
        op_a = {8'b0, sx_mag};
        op_b = {32'b0, slope_mag};
        op_n = sx_r[55] ^ slope_r[31];
      end
      PH_MID: begin
        op_a = {32'b0, slope_mag};
        op_b = {47'b0, xsum_mag};
        op_n = slope_r[31] ^ xsum[16];
      end
      PH_PRED: begin
        op_a = {32'b0, slope_mag};
        op_b = {48'b0, x_mag};
        op_n = slope_r[31] ^ x_r[15];
      end
      PH_SQ: begin
        op_a = {33'b0, err_sat};
        op_b = {33'b0, err_sat};
      end
      PH_ESUM: begin
        op_a = {2'b0, sq_r};
        op_b = {56'b0, w_r};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase

    pp    = ma_r * mb_r[15:0];
    p_add = p_r + ({48'b0, pp} << {dig_r, 4'b0000});
    sp    = mneg_r ? (~{32'b0, p_r} + 160'd1) : {32'b0, p_r};

    s57x = {sx_r[55], sx_r} + {{31{sp[25]}}, sp[25:0]};
    s57y = {sy_r[55], sy_r} + {{31{sp[25]}}, sp[25:0]};
    s65u = {1'b0, sx2_r} + {1'b0, p_r[63:0]};
    s65s = {sxy_r[63], sxy_r} + sp[64:0];

    pq9   = p_r[56:9];
    mid_v = (mneg_r ? (~{16'b0, pq9} + 64'd1) : {16'b0, pq9})
            + {{32{icpt_r[31]}}, icpt_r};
    pq8    = p_r[55:8];
    pred_v = (mneg_r ? (~{16'b0, pq8} + 64'd1) : {16'b0, pq8})
             + {{32{icpt_r[31]}}, icpt_r};
    ysh    = {{40{y_r[15]}}, y_r, 8'b0};

    err_add = (|p_r[127:63]) ? ERR_MAX : p_r[62:0];
    esum_s  = {1'b0, esum_r} + {1'b0, err_add};

    dnum     = (cmd.phase == PH_SLOPE) ? (t1_r <<< 16) : t1_r;
    dden     = (cmd.phase == PH_SLOPE) ? t0_r : {112'b0, sw_r, 8'b0};
    dnum_mag = dnum[159] ? (~dnum + 1'b1) : dnum;
    dden_mag = dden[159] ? (~dden + 1'b1) : dden;
    dge      = (rem_r >= dsh_r);

    qm = q_r[31:0];
    if (dneg_r) begin
      dres = (q_r[32] || qm > 32'h8000_0000) ? 32'sh8000_0000 : (~qm + 1'b1);
    end else begin
      dres = (q_r[32] || qm[31]) ? 32'sh7FFF_FFFF : qm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sw_r        <= '0;
      sx_r        <= '0;
      sy_r        <= '0;
      sx2_r       <= '0;
      sxy_r       <= '0;
      esum_r      <= '0;
      worst_r     <= '0;
      xlo_r       <= '0;
      xhi_r       <= '0;
      ylo_r       <= '0;
      yhi_r       <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_OUT) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (cmd.op)
        OP_CLEAR: begin
          count_r <= '0;
          sw_r    <= '0;
          sx_r    <= '0;
          sy_r    <= '0;
          sx2_r   <= '0;
          sxy_r   <= '0;
          esum_r  <= '0;
          worst_r <= '0;
          xlo_r   <= '0;
          xhi_r   <= '0;
          ylo_r   <= '0;
          yhi_r   <= '0;
        end
        OP_LOAD: begin
          if (count_r == '0 || in_y_value > yhi_r) yhi_r <= in_y_value;
          if (count_r == '0 || in_y_value < ylo_r) ylo_r <= in_y_value;
          if (count_r == '0 || x_eff > xhi_r) xhi_r <= x_eff;
          if (count_r == '0 || x_eff < xlo_r) xlo_r <= x_eff;
          if (count_r != '1) count_r <= cnt1[31:0];
          sw_r <= sw_sum[40] ? SW_MAX : sw_sum[39:0];
        end
        OP_MSTART: begin
          if (cmd.phase == PH_SQ && err_sat > worst_r) worst_r <= err_sat;
        end
        OP_MWB: begin
          case (cmd.phase)
            PH_XW: begin
              if (s57x[56] != s57x[55]) sx_r <= s57x[56] ? S56_MIN : S56_MAX;
              else sx_r <= s57x[55:0];
            end
            PH_YW: begin
              if (s57y[56] != s57y[55]) sy_r <= s57y[56] ? S56_MIN : S56_MAX;
              else sy_r <= s57y[55:0];
            end
            PH_XX: sx2_r <= s65u[64] ? '1 : s65u[63:0];
            PH_XY: begin
              if (s65s[64] != s65s[63]) sxy_r <= s65s[64] ? S64_MIN : S64_MAX;
              else sxy_r <= s65s[63:0];
            end
            PH_ESUM: esum_r <= esum_s[63] ? ERR_MAX : esum_s[62:0];
            default: ;
          endcase
        end
        OP_DSTART: dcnt_r <= DIV_STEPS;
        OP_DSTEP: begin
          if (dcnt_r != '0) dcnt_r <= dcnt_r - 6'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        x_r    <= x_eff;
        y_r    <= in_y_value;
        w_r    <= in_weight;
        flat_r <= 1'b0;
        nowt_r <= 1'b0;
      end
      OP_MSTART: begin
        ma_r   <= op_a;
        mb_r   <= op_b;
        mneg_r <= op_n;
        dig_r  <= '0;
        p_r    <= '0;
        if (cmd.phase == PH_ICPT_M && sw_r == '0) begin
          icpt_r <= '0;
          nowt_r <= 1'b1;
        end
      end
      OP_MSTEP: begin
        if (mb_r != '0) begin
          p_r   <= p_add;
          mb_r  <= mb_r >> 16;
          dig_r <= dig_r + 2'd1;
        end
      end
      OP_MWB: begin
        case (cmd.phase)
          PH_XW:     xw_r <= sp[25:0];
          PH_YW:     yw_r <= sp[25:0];
          PH_DEN0:   t0_r <= sp;
          PH_DEN1:   t0_r <= t0_r - (sp <<< 4);
          PH_NUM0:   t1_r <= sp;
          PH_NUM1:   t1_r <= t1_r - (sp <<< 4);
          PH_ICPT_M: t1_r <= ({{104{sy_r[55]}}, sy_r} <<< 16) - sp;
          PH_MID:    mid_r <= sat32(mid_v);
          PH_PRED:   e_r <= ysh - pred_v;
          PH_SQ:     sq_r <= p_r[61:0];
          default: ;
        endcase
      end
      OP_DSTART: begin
        if (cmd.phase == PH_SLOPE && t0_r == '0) begin
          slope_r <= '0;
          flat_r  <= 1'b1;
        end
        rem_r  <= dnum_mag;
        dsh_r  <= dden_mag << 32;
        dneg_r <= dnum[159] ^ dden[159];
        q_r    <= '0;
      end
      OP_DSTEP: begin
        if (dcnt_r != '0) begin
          if (dge) rem_r <= rem_r - dsh_r;
          q_r   <= {q_r[31:0], dge};
          dsh_r <= dsh_r >> 1;
        end
      end
      OP_DWB: begin
        if (cmd.phase == PH_SLOPE) slope_r <= dres;
        else icpt_r <= dres;
      end
      OP_OUT: begin
        o_slope_r <= slope_r;
        o_icpt_r  <= icpt_r;
        o_mid_r   <= mid_r;
        o_worst_r <= worst_r;
        o_esum_r  <= esum_r;
        o_ylo_r   <= ylo_r;
        o_yhi_r   <= yhi_r;
        o_xlo_r   <= xlo_r;
        o_xhi_r   <= xhi_r;
        o_count_r <= count_r;
        o_flat_r  <= flat_r;
        o_nowt_r  <= nowt_r;
      end
      default: ;
    endcase
  end

  assign sts.mul_done = (mb_r == '0);
  assign sts.div_done = (dcnt_r == '0);
  assign sts.den_zero = (t0_r == '0);
  assign sts.sw_zero  = (sw_r == '0);
  assign sts.out_busy = out_valid_r && !out_ready;

  assign out_valid       = out_valid_r;
  assign out_slope       = o_slope_r;
  assign out_intercept   = o_icpt_r;
  assign out_mid_value   = o_mid_r;
  assign out_max_error   = o_worst_r;
  assign out_error_sum   = o_esum_r;
  assign out_y_low       = o_ylo_r;
  assign out_y_high      = o_yhi_r;
  assign out_x_low       = o_xlo_r;
  assign out_x_high      = o_xhi_r;
  assign out_point_count = o_count_r;
  assign out_flat_fit    = o_flat_r;
  assign out_no_weight   = o_nowt_r;

  a_worst_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op != OP_CLEAR |=> worst_r >= $past(worst_r))
    else $error("max error dropped without clear");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.op == OP_OUT))
    else $error("result word raised without load");

endmodule

[hdl/weighted_linear_fit_tracker_unit.sv]
// Weighted linear fit tracker. Each point word updates the running weighted
// sums and refits slope, intercept, the line value at the x midpoint and the
// error statistics; a clear word resets the running sums, the point count,
// the bounds and the error statistics and returns nothing. A point must be
// finished before the next word can be taken: thirteen products go through
// one shared 64x16 multiplier that takes one 16-bit digit of its second
// operand per cycle and stops at the last nonzero digit (four digits at
// most), and slope and intercept each go through one shared 160-bit divider
// (33 compare-subtract steps). Short operands, a zero slope denominator or a
// zero weight sum shorten the work. The finished result sits in an output
// register, so the next word is taken while it waits.
module weighted_linear_fit_tracker_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic signed [15:0] in_x_value,
  input  logic signed [15:0] in_y_value,
  input  logic [7:0]         in_weight,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_slope,
  output logic signed [31:0] out_intercept,
  output logic signed [31:0] out_mid_value,
  output logic [30:0]        out_max_error,
  output logic [62:0]        out_error_sum,
  output logic signed [15:0] out_y_low,
  output logic signed [15:0] out_y_high,
  output logic signed [15:0] out_x_low,
  output logic signed [15:0] out_x_high,
  output logic [31:0]        out_point_count,
  output logic               out_flat_fit,
  output logic               out_no_weight
);
  import wlft_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wlft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .sts      (sts),
    .cmd      (cmd)
  );

  wlft_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_cmd          (in_cmd),
    .in_x_value      (in_x_value),
    .in_y_value      (in_y_value),
    .in_weight       (in_weight),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_slope       (out_slope),
    .out_intercept   (out_intercept),
    .out_mid_value   (out_mid_value),
    .out_max_error   (out_max_error),
    .out_error_sum   (out_error_sum),
    .out_y_low       (out_y_low),
    .out_y_high      (out_y_high),
    .out_x_low       (out_x_low),
    .out_x_high      (out_x_high),
    .out_point_count (out_point_count),
    .out_flat_fit    (out_flat_fit),
    .out_no_weight   (out_no_weight)
  );

endmodule
